### hdl/euler_to_quaternion_defines.svh
// Assertion macros shared by the euler_to_quaternion checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// implication checked only outside reset
`define EQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("euler_to_quaternion check failed");

// implication checked on every edge, reset included
`define EQ_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("euler_to_quaternion check failed");

`endif

### hdl/eq_pkg.sv
// Types and constants for the Euler angle to quaternion converter.
// No dependencies.
`default_nettype none
package eq_pkg;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ZW = 34;               // internal CORDIC word, 30 fraction bits

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [15:0]   ONE_Q14     = 16'sd16384;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd66987894,
        32'd33553755, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
        32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_euler;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [ZW-1:0] x;
        logic signed [ZW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } t_lane;

    // lane 2 roll, lane 1 pitch, lane 0 yaw
    typedef struct packed {
        logic            vld;
        t_lane [2:0]     lane;
    } t_cell_beat;
endpackage
`default_nettype wire

### hdl/eq_cordic_cell.sv
// One CORDIC rotation stage for the three angle lanes, registered.
// Uses eq_pkg.
`default_nettype none
module eq_cordic_cell import eq_pkg::*; #(
    parameter int STAGE = 0
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cell_beat i_beat,
    output t_cell_beat o_beat
);
    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_Q30[STAGE]);

    t_cell_beat r_beat, n_beat;

    always_comb begin
        n_beat.vld = i_beat.vld;
        for (int k = 0; k < 3; k++) begin
            n_beat.lane[k].neg = i_beat.lane[k].neg;
            if (!i_beat.lane[k].z[ZW-1]) begin
                n_beat.lane[k].x = i_beat.lane[k].x - (i_beat.lane[k].y >>> STAGE);
                n_beat.lane[k].y = i_beat.lane[k].y + (i_beat.lane[k].x >>> STAGE);
                n_beat.lane[k].z = i_beat.lane[k].z - ANG;
            end else begin
                n_beat.lane[k].x = i_beat.lane[k].x + (i_beat.lane[k].y >>> STAGE);
                n_beat.lane[k].y = i_beat.lane[k].y - (i_beat.lane[k].x >>> STAGE);
                n_beat.lane[k].z = i_beat.lane[k].z + ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat.lane <= n_beat.lane;
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else begin
            r_beat.vld <= n_beat.vld;
        end
    end

    assign o_beat = r_beat;
endmodule
`default_nettype wire

### hdl/eq_combine.sv
// Quaternion product tree: pair products, triple products, round and clamp.
// Three register stages. Uses eq_pkg.
`default_nettype none
module eq_combine import eq_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cell_beat i_beat,
    output logic       o_valid,
    output t_quat      o_quat
);
    localparam int PW = 64;
    localparam int TW = 67;

    logic signed [31:0] c [3];
    logic signed [31:0] s [3];

    logic               r_v1, r_v2, r_v3;
    logic signed [33:0] r_crcp, r_srsp, r_srcp, r_crsp;
    logic signed [31:0] r_cy, r_sy;
    logic signed [TW-1:0] r_t [8];
    t_quat              r_quat, n_quat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c[k] = 32'(i_beat.lane[k].neg ? -i_beat.lane[k].x : i_beat.lane[k].x);
            s[k] = 32'(i_beat.lane[k].neg ? -i_beat.lane[k].y : i_beat.lane[k].y);
        end
    end

    function automatic logic signed [33:0] pair(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return 34'(p >>> 30);
    endfunction

    function automatic logic signed [15:0] finish(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [TW:0] sum;
        logic signed [TW:0] q;
        sum = (TW+1)'(a) + (TW+1)'(b) + ((TW+1)'(1) <<< 45);
        q   = sum >>> 46;
        if (q > (TW+1)'(ONE_Q14)) begin
            return ONE_Q14;
        end else if (q < -(TW+1)'(ONE_Q14)) begin
            return -ONE_Q14;
        end
        return 16'(q);
    endfunction

    function automatic logic signed [TW-1:0] tmul(input logic signed [33:0] a,
                                                  input logic signed [31:0] b);
        return TW'(a) * TW'(b);
    endfunction

    // lane 2 roll, 1 pitch, 0 yaw
    always_ff @(posedge i_clk) begin
        r_crcp <= pair(c[2], c[1]);
        r_srsp <= pair(s[2], s[1]);
        r_srcp <= pair(s[2], c[1]);
        r_crsp <= pair(c[2], s[1]);
        r_cy   <= c[0];
        r_sy   <= s[0];
        r_t[0] <= tmul(r_crcp, r_cy);
        r_t[1] <= tmul(r_srsp, r_sy);
        r_t[2] <= tmul(r_srcp, r_cy);
        r_t[3] <= -tmul(r_crsp, r_sy);
        r_t[4] <= tmul(r_crsp, r_cy);
        r_t[5] <= tmul(r_srcp, r_sy);
        r_t[6] <= tmul(r_crcp, r_sy);
        r_t[7] <= -tmul(r_srsp, r_cy);
        r_quat <= n_quat;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_beat.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_quat.quat_w = finish(r_t[0], r_t[1]);
        n_quat.quat_x = finish(r_t[2], r_t[3]);
        n_quat.quat_y = finish(r_t[4], r_t[5]);
        n_quat.quat_z = finish(r_t[6], r_t[7]);
    end

    assign o_valid = r_v3;
    assign o_quat  = r_quat;
endmodule
`default_nettype wire

### hdl/euler_to_quaternion.sv
// Euler angles (roll, pitch, yaw) to unit quaternion, ZYX convention.
// Uses eq_pkg, eq_cordic_cell, eq_combine.
//
// Fully pipelined: a beat is taken on every cycle that i_start is high (o_busy
// stays low), and its quaternion appears on o_quat with o_valid high once it has
// passed one fold stage, one CORDIC cell per stage and three product/round
// stages. Results cannot be held off by the receiver.
`default_nettype none
module euler_to_quaternion import eq_pkg::*; #(
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_start,
    input  t_euler i_angles,
    output logic   o_busy,
    output logic   o_valid,
    output t_quat  o_quat
);
    localparam int SH = 32 - ANGLE_WIDTH;

    logic [15:0]  raw [3];
    t_cell_beat   n_prep, r_prep;
    t_cell_beat   beat [CORDIC_STAGES+1];

    assign raw[2] = i_angles.roll_angle;
    assign raw[1] = i_angles.pitch_angle;
    assign raw[0] = i_angles.yaw_angle;

    // half angle in Q2.30, folded into +-pi/2
    always_comb begin
        logic signed [31:0]   h32;
        logic signed [ZW-1:0] h;
        n_prep.vld = i_start;
        for (int k = 0; k < 3; k++) begin
            h32 = $signed({16'b0, raw[k]} << SH);
            h   = ZW'(h32);
            n_prep.lane[k].x   = GAIN_Q30;
            n_prep.lane[k].y   = '0;
            n_prep.lane[k].neg = 1'b0;
            n_prep.lane[k].z   = h;
            if (h > HALF_PI_Q30) begin
                n_prep.lane[k].z   = h - PI_Q30;
                n_prep.lane[k].neg = 1'b1;
            end else if (h < -HALF_PI_Q30) begin
                n_prep.lane[k].z   = h + PI_Q30;
                n_prep.lane[k].neg = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prep.lane <= n_prep.lane;
        if (!i_rst_n) begin
            r_prep.vld <= 1'b0;
        end else begin
            r_prep.vld <= n_prep.vld;
        end
    end

    assign beat[0] = r_prep;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        eq_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_beat (beat[g]),
            .o_beat (beat[g+1])
        );
    end

    eq_combine u_combine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_beat (beat[CORDIC_STAGES]),
        .o_valid(o_valid),
        .o_quat (o_quat)
    );

    assign o_busy = 1'b0;
endmodule
`default_nettype wire

### hdl/eq_checker.sv
// Port-level checks for euler_to_quaternion, bound to the top level.
// Uses eq_pkg and euler_to_quaternion_defines.svh.
`include "euler_to_quaternion_defines.svh"
`default_nettype none
module eq_checker import eq_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input wire    i_clk,
    input wire    i_rst_n,
    input wire    i_start,
    input wire    o_busy,
    input wire    o_valid,
    input t_quat  o_quat
);
    localparam int LATENCY = CORDIC_STAGES + 4;

    `EQ_ASSERT_IMP(a_never_busy, 1'b1, !o_busy)
    `EQ_ASSERT_IMP(a_valid_has_start, o_valid, $past(i_start, LATENCY))
    `EQ_ASSERT_ALWAYS(a_quiet_after_reset, !i_rst_n ##1 1'b1, !o_valid)
    `EQ_ASSERT_IMP(a_unit_range, o_valid,
        o_quat.quat_w <= ONE_Q14 && o_quat.quat_w >= -ONE_Q14 &&
        o_quat.quat_x <= ONE_Q14 && o_quat.quat_x >= -ONE_Q14 &&
        o_quat.quat_y <= ONE_Q14 && o_quat.quat_y >= -ONE_Q14 &&
        o_quat.quat_z <= ONE_Q14 && o_quat.quat_z >= -ONE_Q14)
endmodule

bind euler_to_quaternion eq_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_eq_checker (.*);
`default_nettype wire
